[hdl/teq_pkg.sv]
// Shared types, codes and default sizes for the timed event queue.
// Used by teq_ctrl, teq_dpath and timed_event_queue; depends on nothing.
package teq_pkg;

  localparam int DEPTH_DEF     = 16;
  localparam int TIME_BITS_DEF = 32;
  localparam int ID_BITS_DEF   = 8;
  localparam int OP_BITS       = 2;
  localparam int KIND_BITS     = 3;

  // operation carried in the input tuser
  typedef enum logic [OP_BITS-1:0] {
    OP_TICK   = 2'd0,
    OP_SCHED  = 2'd1,
    OP_CANCEL = 2'd2
  } op_t;

  // result kind carried in the output tuser
  typedef enum logic [KIND_BITS-1:0] {
    KIND_FIRED  = 3'd0,
    KIND_IDLE   = 3'd1,
    KIND_SCHED  = 3'd2,
    KIND_FULL   = 3'd3,
    KIND_CANCEL = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TICK,
    ST_SCHED,
    ST_INSERT,
    ST_SCAN,
    ST_CANCEL,
    ST_NOP
  } state_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic  load;
    logic  calc;
    logic  insert;
    logic  pop;
    logic  scan_step;
    logic  emit;
    kind_t kind;
    logic  last;
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic due0;
    logic due1;
    logic full;
    logic scan_done;
    logic out_free;
  } sts_t;

endpackage

[hdl/timed_event_queue.sv]
// Top level of the timed event queue: stream ports, packing, assertions.
// Depends on teq_pkg, teq_ctrl and teq_dpath.
//
//  channel  | direction | tuser          | tdata (lowest bit up)
//  ---------+-----------+----------------+------------------------------------------
//  in_      | slave     | op             | time_now, delay, receiver_id, action_id
//  out_     | master    | kind           | fired_receiver, fired_action, removed_count
//
// Steps: a tick is accepted, then gives one result per fired event (one idle
// result when nothing is due); a schedule is accepted, adds the deadline and
// inserts, or reports full when the queue is full; a cancel is accepted, rotates the slot chain one slot
// a cycle past each stored event, then reports. An unused op gives an idle result.
// Reset: rst_n low, synchronous, empties the queue and drops any pending item.
// Stalls: a result waits in the output register; the next input item is taken
// while it waits, and the controller holds before loading a further result.
module timed_event_queue #(
  parameter int DEPTH     = teq_pkg::DEPTH_DEF,
  parameter int TIME_BITS = teq_pkg::TIME_BITS_DEF,
  parameter int ID_BITS   = teq_pkg::ID_BITS_DEF,
  localparam int CNT_W    = $clog2(DEPTH + 1),
  localparam int IN_W     = 2 * TIME_BITS + 2 * ID_BITS,
  localparam int IN_TW    = ((IN_W + 7) / 8) * 8,
  localparam int OUT_W    = 2 * ID_BITS + CNT_W,
  localparam int OUT_TW   = ((OUT_W + 7) / 8) * 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // time_now, delay, receiver_id, action_id
  input  logic [IN_TW-1:0]              in_tdata,
  // op
  input  logic [teq_pkg::OP_BITS-1:0]   in_tuser,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // fired_receiver, fired_action, removed_count
  output logic [OUT_TW-1:0]             out_tdata,
  // kind
  output logic [teq_pkg::KIND_BITS-1:0] out_tuser,
  output logic                          out_tlast
);

  teq_pkg::cmd_t  cmd;
  teq_pkg::sts_t  sts;
  teq_pkg::kind_t out_kind;
  logic [ID_BITS-1:0] out_receiver, out_action;
  logic [CNT_W-1:0]   out_count, entry_count;

  // accept only from the idle state; the datapath latches the item on acceptance
  teq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_op    (in_tuser),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  teq_dpath #(
    .DEPTH     (DEPTH),
    .TIME_BITS (TIME_BITS),
    .ID_BITS   (ID_BITS)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_time_now    (in_tdata[TIME_BITS-1:0]),
    .in_delay       (in_tdata[2*TIME_BITS-1:TIME_BITS]),
    .in_receiver_id (in_tdata[2*TIME_BITS+ID_BITS-1:2*TIME_BITS]),
    .in_action_id   (in_tdata[2*TIME_BITS+2*ID_BITS-1:2*TIME_BITS+ID_BITS]),
    .cmd            (cmd),
    .sts            (sts),
    .out_ready      (out_tready),
    .out_valid      (out_tvalid),
    .out_kind       (out_kind),
    .out_receiver   (out_receiver),
    .out_action     (out_action),
    .out_count      (out_count),
    .out_last       (out_tlast),
    .entry_count    (entry_count)
  );

  // pack the result, zero fill to whole bytes
  assign out_tdata = OUT_TW'({out_count, out_action, out_receiver});
  assign out_tuser = out_kind;

  // the fill level stays within the slot count
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    entry_count <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  // the fill level moves by at most one slot per cycle
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (entry_count == $past(entry_count) ||
                      entry_count == $past(entry_count) + CNT_W'(1) ||
                      entry_count + CNT_W'(1) == $past(entry_count)))
    else $error("entry count jumped");

  // one item at a time: an accepted item takes the controller out of idle
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("second item taken while busy");

  // a result is only loaded into a free output register
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_tvalid || out_tready))
    else $error("result overwritten while stalled");

endmodule

[hdl/teq_ctrl.sv]
// Controller state machine of the timed event queue.
// Depends on teq_pkg; drives teq_dpath through cmd_t and reads sts_t.
module teq_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic [teq_pkg::OP_BITS-1:0] in_op,
  output logic                        in_ready,
  input  teq_pkg::sts_t               sts,
  output teq_pkg::cmd_t               cmd
);

  teq_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= teq_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      teq_pkg::ST_IDLE: begin
        if (in_valid) begin
          case (teq_pkg::op_t'(in_op))
            teq_pkg::OP_TICK:   state_nxt = teq_pkg::ST_TICK;
            teq_pkg::OP_SCHED:  state_nxt = teq_pkg::ST_SCHED;
            teq_pkg::OP_CANCEL: state_nxt = teq_pkg::ST_SCAN;
            default:            state_nxt = teq_pkg::ST_NOP;
          endcase
        end
      end
      teq_pkg::ST_TICK: begin
        if (sts.out_free && !(sts.due0 && sts.due1)) state_nxt = teq_pkg::ST_IDLE;
      end
      teq_pkg::ST_SCHED: begin
        if (!sts.full) state_nxt = teq_pkg::ST_INSERT;
        else if (sts.out_free) state_nxt = teq_pkg::ST_IDLE;
      end
      teq_pkg::ST_INSERT: begin
        if (sts.out_free) state_nxt = teq_pkg::ST_IDLE;
      end
      teq_pkg::ST_SCAN: begin
        if (sts.scan_done) state_nxt = teq_pkg::ST_CANCEL;
      end
      teq_pkg::ST_CANCEL, teq_pkg::ST_NOP: begin
        if (sts.out_free) state_nxt = teq_pkg::ST_IDLE;
      end
      default: state_nxt = teq_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.kind      = teq_pkg::KIND_IDLE;
    cmd.last      = 1'b1;
    case (state_r)
      teq_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      teq_pkg::ST_TICK: begin
        cmd.emit = sts.out_free;
        cmd.pop  = sts.out_free && sts.due0;
        cmd.kind = sts.due0 ? teq_pkg::KIND_FIRED : teq_pkg::KIND_IDLE;
        cmd.last = !(sts.due0 && sts.due1);
      end
      teq_pkg::ST_SCHED: begin
        cmd.calc = !sts.full;
        cmd.emit = sts.full && sts.out_free;
        cmd.kind = teq_pkg::KIND_FULL;
      end
      teq_pkg::ST_INSERT: begin
        cmd.emit   = sts.out_free;
        cmd.insert = sts.out_free;
        cmd.kind   = teq_pkg::KIND_SCHED;
      end
      teq_pkg::ST_SCAN: begin
        cmd.scan_step = !sts.scan_done;
      end
      teq_pkg::ST_CANCEL: begin
        cmd.emit = sts.out_free;
        cmd.kind = teq_pkg::KIND_CANCEL;
      end
      teq_pkg::ST_NOP: begin
        cmd.emit = sts.out_free;
      end
      default: begin
        cmd.emit = 1'b0;
      end
    endcase
  end

endmodule

[hdl/teq_dpath.sv]
// Datapath of the timed event queue: sorted slot chain, deadline adder,
// cancel scan counters and the result register. Depends on teq_pkg.
module teq_dpath #(
  parameter int DEPTH     = teq_pkg::DEPTH_DEF,
  parameter int TIME_BITS = teq_pkg::TIME_BITS_DEF,
  parameter int ID_BITS   = teq_pkg::ID_BITS_DEF,
  localparam int CNT_W    = $clog2(DEPTH + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [TIME_BITS-1:0]  in_time_now,
  input  logic [TIME_BITS-1:0]  in_delay,
  input  logic [ID_BITS-1:0]    in_receiver_id,
  input  logic [ID_BITS-1:0]    in_action_id,
  input  teq_pkg::cmd_t         cmd,
  output teq_pkg::sts_t         sts,
  input  logic                  out_ready,
  output logic                  out_valid,
  output teq_pkg::kind_t        out_kind,
  output logic [ID_BITS-1:0]    out_receiver,
  output logic [ID_BITS-1:0]    out_action,
  output logic [CNT_W-1:0]      out_count,
  output logic                  out_last,
  output logic [CNT_W-1:0]      entry_count
);

  // latched input item
  logic [TIME_BITS-1:0] now_r, dly_r, new_dl_r;
  logic [ID_BITS-1:0]   rcv_r, act_r;

  // slot chain, kept sorted by deadline from slot 0
  logic [TIME_BITS-1:0] dl_r  [DEPTH];
  logic [ID_BITS-1:0]   rid_r [DEPTH];
  logic [ID_BITS-1:0]   aid_r [DEPTH];
  logic [TIME_BITS-1:0] dl_nxt  [DEPTH];
  logic [ID_BITS-1:0]   rid_nxt [DEPTH];
  logic [ID_BITS-1:0]   aid_nxt [DEPTH];
  logic [TIME_BITS-1:0] dl_up  [DEPTH];
  logic [ID_BITS-1:0]   rid_up [DEPTH];
  logic [ID_BITS-1:0]   aid_up [DEPTH];

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] remain_r, removed_r;
  logic [DEPTH-1:0] used, le_new, is_tail;
  logic             keep_head;
  logic [TIME_BITS:0] sum;

  logic                 out_valid_r;
  teq_pkg::kind_t       out_kind_r;
  logic [ID_BITS-1:0]   out_rcv_r, out_act_r;
  logic [CNT_W-1:0]     out_cnt_r;
  logic                 out_last_r;

  // neighbour above each slot; the top slot holds itself
  for (genvar g = 0; g < DEPTH; g++) begin : g_up
    if (g < DEPTH - 1) begin : g_mid
      assign dl_up[g]  = dl_r[g+1];
      assign rid_up[g] = rid_r[g+1];
      assign aid_up[g] = aid_r[g+1];
    end else begin : g_top
      assign dl_up[g]  = dl_r[g];
      assign rid_up[g] = rid_r[g];
      assign aid_up[g] = aid_r[g];
    end
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      used[i]    = CNT_W'(i) < count_r;
      le_new[i]  = used[i] && (dl_r[i] <= new_dl_r);
      is_tail[i] = CNT_W'(i) == (count_r - CNT_W'(1));
    end
  end

  assign keep_head = rcv_r != rid_r[0];
  assign sum       = {1'b0, now_r} + {1'b0, dly_r};

  // next slot contents
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      dl_nxt[i]  = dl_r[i];
      rid_nxt[i] = rid_r[i];
      aid_nxt[i] = aid_r[i];
      if (cmd.insert) begin
        if (!le_new[i]) begin
          if (i == 0 || le_new[(i == 0) ? 0 : i-1]) begin
            dl_nxt[i]  = new_dl_r;
            rid_nxt[i] = rcv_r;
            aid_nxt[i] = act_r;
          end else begin
            dl_nxt[i]  = dl_r[(i == 0) ? 0 : i-1];
            rid_nxt[i] = rid_r[(i == 0) ? 0 : i-1];
            aid_nxt[i] = aid_r[(i == 0) ? 0 : i-1];
          end
        end
      end else if (cmd.pop || cmd.scan_step) begin
        // shift down; a scanned head that stays rotates to the tail
        if (cmd.scan_step && keep_head && is_tail[i]) begin
          dl_nxt[i]  = dl_r[0];
          rid_nxt[i] = rid_r[0];
          aid_nxt[i] = aid_r[0];
        end else begin
          dl_nxt[i]  = dl_up[i];
          rid_nxt[i] = rid_up[i];
          aid_nxt[i] = aid_up[i];
        end
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.insert) count_nxt = count_r + CNT_W'(1);
    else if (cmd.pop || (cmd.scan_step && !keep_head)) count_nxt = count_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      dl_r[i]  <= dl_nxt[i];
      rid_r[i] <= rid_nxt[i];
      aid_r[i] <= aid_nxt[i];
    end
    if (cmd.load) begin
      now_r <= in_time_now;
      dly_r <= in_delay;
      rcv_r <= in_receiver_id;
      act_r <= in_action_id;
    end
    // saturate the deadline on carry out
    if (cmd.calc) new_dl_r <= sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      remain_r  <= '0;
      removed_r <= '0;
    end else begin
      count_r <= count_nxt;
      if (cmd.load) begin
        remain_r  <= count_r;
        removed_r <= '0;
      end else if (cmd.scan_step) begin
        remain_r <= remain_r - CNT_W'(1);
        if (!keep_head) removed_r <= removed_r + CNT_W'(1);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_kind_r <= cmd.kind;
      out_last_r <= cmd.last;
      out_rcv_r  <= (cmd.kind == teq_pkg::KIND_FIRED) ? rid_r[0] : '0;
      out_act_r  <= (cmd.kind == teq_pkg::KIND_FIRED) ? aid_r[0] : '0;
      out_cnt_r  <= (cmd.kind == teq_pkg::KIND_CANCEL) ? removed_r : '0;
    end
  end

  assign sts.due0      = used[0] && (dl_r[0] <= now_r);
  assign sts.due1      = used[1] && (dl_r[1] <= now_r);
  assign sts.full      = count_r == CNT_W'(DEPTH);
  assign sts.scan_done = remain_r == '0;
  assign sts.out_free  = !out_valid_r || out_ready;

  assign out_valid    = out_valid_r;
  assign out_kind     = out_kind_r;
  assign out_receiver = out_rcv_r;
  assign out_action   = out_act_r;
  assign out_count    = out_cnt_r;
  assign out_last     = out_last_r;
  assign entry_count  = count_r;

endmodule
